// ----- sv/epc_pkg.sv -----
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants for the epoch to calendar converter
// command and status structs between controller and datapath, divide
// operation codes and the month length table
// ----------------------------------------------------------------------------
package epc_pkg;

	// divide operations, run in this order for every request
	typedef logic [2:0] op_t;
	localparam op_t OP_DAY  = 3'd0;  // seconds by seconds per day
	localparam op_t OP_HOUR = 3'd1;  // time of day by seconds per hour
	localparam op_t OP_MIN  = 3'd2;  // seconds of hour by seconds per minute
	localparam op_t OP_CYC  = 3'd3;  // days by days per 400 years
	localparam op_t OP_MS   = 3'd4;  // nanoseconds by nanoseconds per milli

	localparam int unsigned DIVISOR_W    = 20;
	localparam int unsigned EPOCH_YEAR   = 1970;
	localparam int unsigned SEC_PER_MIN  = 60;
	localparam int unsigned SEC_PER_HOUR = 3600;
	localparam int unsigned SEC_PER_DAY  = 86400;
	localparam int unsigned DAYS_PER_400Y = 146097;
	localparam int unsigned NANO_PER_MS  = 1000000;
	localparam int unsigned MILLIS_MAX   = 999;
	localparam int unsigned YEAR_LEN     = 365;
	localparam int unsigned YEAR_CYCLE   = 400;
	localparam int unsigned NANOS_W      = 30;
	localparam int unsigned RESULT_W     = 48;

	typedef struct packed {
		logic load;       // latch a new request
		logic div_start;  // start the divider on op
		logic div_save;   // store divider result for op
		op_t  op;
		logic year_step;  // remove one year
		logic month_step; // remove one month
		logic out_load;   // move the result to the output register
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic year_more;
		logic month_more;
		logic out_free;
	} sts_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd3:    len = 5'd30;
			4'd5:    len = 5'd30;
			4'd8:    len = 5'd30;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- sv/epc_div.sv -----
// ----------------------------------------------------------------------------
// epc_div: constant divider
// eight quotient bits at a time by reciprocal multiplication, divisor
// picked by op, quotient and remainder valid when done pulses
// ----------------------------------------------------------------------------
module epc_div #(
	parameter int unsigned DW = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  epc_pkg::op_t                  op,
	input  logic [DW-1:0]                 dividend,
	output logic                          done,
	output logic [DW-1:0]                 quo,
	output logic [epc_pkg::DIVISOR_W-1:0] rem
);
	import epc_pkg::*;

	localparam int unsigned NDIG   = DW / 8;
	localparam int unsigned CNT_W  = $clog2(2 * NDIG + 1);
	localparam int unsigned VAL_W  = DIVISOR_W + 8;
	localparam int unsigned MUL_W  = VAL_W + 2;
	localparam int unsigned PROD_W = VAL_W + MUL_W;

	// reciprocals, exact for any partial dividend below 2**VAL_W
	localparam int unsigned SH_DAY  = VAL_W + $clog2(SEC_PER_DAY);
	localparam int unsigned SH_HOUR = VAL_W + $clog2(SEC_PER_HOUR);
	localparam int unsigned SH_MIN  = VAL_W + $clog2(SEC_PER_MIN);
	localparam int unsigned SH_CYC  = VAL_W + $clog2(DAYS_PER_400Y);
	localparam int unsigned SH_MS   = VAL_W + $clog2(NANO_PER_MS);
	localparam logic [MUL_W-1:0] M_DAY  =
		MUL_W'(((64'd1 << SH_DAY) + SEC_PER_DAY - 1) / SEC_PER_DAY);
	localparam logic [MUL_W-1:0] M_HOUR =
		MUL_W'(((64'd1 << SH_HOUR) + SEC_PER_HOUR - 1) / SEC_PER_HOUR);
	localparam logic [MUL_W-1:0] M_MIN  =
		MUL_W'(((64'd1 << SH_MIN) + SEC_PER_MIN - 1) / SEC_PER_MIN);
	localparam logic [MUL_W-1:0] M_CYC  =
		MUL_W'(((64'd1 << SH_CYC) + DAYS_PER_400Y - 1) / DAYS_PER_400Y);
	localparam logic [MUL_W-1:0] M_MS   =
		MUL_W'(((64'd1 << SH_MS) + NANO_PER_MS - 1) / NANO_PER_MS);

	logic [DW-1:0]          shf_q;
	logic [DIVISOR_W-1:0]   rem_q;
	logic [VAL_W-1:0]       val_q;
	logic [PROD_W-1:0]      prod_q;
	op_t                    sel_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [VAL_W-1:0]       val;
	logic [MUL_W-1:0]       mul;
	logic [DIVISOR_W-1:0]   dvs;
	logic [7:0]             qdig;
	logic [VAL_W-1:0]       rem_d;

	assign val = {rem_q, shf_q[DW-1 -: 8]};

	always_comb begin
		case (sel_q)
			OP_DAY: begin
				mul  = M_DAY;
				dvs  = DIVISOR_W'(SEC_PER_DAY);
				qdig = 8'(prod_q >> SH_DAY);
			end
			OP_HOUR: begin
				mul  = M_HOUR;
				dvs  = DIVISOR_W'(SEC_PER_HOUR);
				qdig = 8'(prod_q >> SH_HOUR);
			end
			OP_MIN: begin
				mul  = M_MIN;
				dvs  = DIVISOR_W'(SEC_PER_MIN);
				qdig = 8'(prod_q >> SH_MIN);
			end
			OP_CYC: begin
				mul  = M_CYC;
				dvs  = DIVISOR_W'(DAYS_PER_400Y);
				qdig = 8'(prod_q >> SH_CYC);
			end
			default: begin
				mul  = M_MS;
				dvs  = DIVISOR_W'(NANO_PER_MS);
				qdig = 8'(prod_q >> SH_MS);
			end
		endcase
	end

	assign rem_d = val_q - VAL_W'(qdig) * VAL_W'(dvs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(2 * NDIG);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// even count: multiply, odd count: take the digit and the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= dividend;
			rem_q <= '0;
			sel_q <= op;
		end else if (cnt_q != '0) begin
			if (!cnt_q[0]) begin
				val_q  <= val;
				prod_q <= PROD_W'(val) * PROD_W'(mul);
			end else begin
				shf_q <= {shf_q[DW-9:0], qdig};
				rem_q <= DIVISOR_W'(rem_d);
			end
		end
	end

	assign done = done_q;
	assign quo  = shf_q;
	assign rem  = rem_q;

endmodule

// ----- sv/epc_dp.sv -----
// ----------------------------------------------------------------------------
// epc_dp: converter datapath
// request registers, shared divider, year and month counters, output register
// ----------------------------------------------------------------------------
module epc_dp #(
	parameter int unsigned SW = 34
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  epc_pkg::cmd_t               cmd,
	output epc_pkg::sts_t               sts,
	input  logic [SW-1:0]               secs,
	input  logic [epc_pkg::NANOS_W-1:0] nanos,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [epc_pkg::RESULT_W-1:0] out_data
);
	import epc_pkg::*;

	localparam int unsigned DW     = ((((SW > NANOS_W) ? SW : NANOS_W) + 7) / 8) * 8;
	localparam int unsigned DAYS_W = (SW - 16 > 18) ? SW - 16 : 18;

	logic [SW-1:0]        secs_q;
	logic [NANOS_W-1:0]   nanos_q;
	logic [DAYS_W-1:0]    days_q;
	logic [16:0]          tod_q;
	logic [4:0]           hour_q;
	logic [5:0]           min_q;
	logic [5:0]           sec_q;
	logic [9:0]           ms_q;
	logic [11:0]          year_q;
	logic [8:0]           y400_q;
	logic [3:0]           mon_q;
	logic                 out_vld_q;
	logic [RESULT_W-1:0]  out_q;

	logic [DW-1:0]        dvd;
	logic                 div_done;
	logic [DW-1:0]        quo;
	logic [DIVISOR_W-1:0] rem;
	logic                 leap;
	logic [DAYS_W-1:0]    ylen;
	logic [DAYS_W-1:0]    mlen;

	always_comb begin
		case (cmd.op)
			OP_DAY:  begin dvd = DW'(secs_q);  end
			OP_HOUR: begin dvd = DW'(tod_q);   end
			OP_MIN:  begin dvd = DW'(tod_q);   end
			OP_CYC:  begin dvd = DW'(days_q);  end
			OP_MS:   begin dvd = DW'(nanos_q); end
			default: begin dvd = DW'(nanos_q); end
		endcase
	end

	epc_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.op       (cmd.op),
		.dividend (dvd),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	// gregorian rule on the year within its 400 year cycle
	assign leap = (y400_q[1:0] == 2'd0) && (y400_q != 9'd100) && (y400_q != 9'd200)
		&& (y400_q != 9'd300);
	assign ylen = DAYS_W'(YEAR_LEN) + DAYS_W'(leap);
	assign mlen = DAYS_W'(month_len(leap, mon_q));

	assign sts.div_done   = div_done;
	assign sts.year_more  = days_q >= ylen;
	assign sts.month_more = (mon_q < 4'd11) && (days_q >= mlen);
	assign sts.out_free   = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			secs_q  <= secs;
			nanos_q <= nanos;
		end
		if (cmd.div_save) begin
			case (cmd.op)
				OP_DAY: begin
					days_q <= DAYS_W'(quo);
					tod_q  <= 17'(rem);
				end
				OP_HOUR: begin
					hour_q <= 5'(quo);
					tod_q  <= 17'(rem);
				end
				OP_MIN: begin
					min_q <= 6'(quo);
					sec_q <= 6'(rem);
				end
				OP_CYC: begin
					days_q <= DAYS_W'(rem);
					year_q <= 12'(12'(EPOCH_YEAR) + 12'(quo) * 12'(YEAR_CYCLE));
					y400_q <= 9'(EPOCH_YEAR % YEAR_CYCLE);
					mon_q  <= '0;
				end
				default: begin
					ms_q <= (quo > DW'(MILLIS_MAX)) ? 10'(MILLIS_MAX) : 10'(quo);
				end
			endcase
		end
		if (cmd.year_step) begin
			days_q <= days_q - ylen;
			year_q <= year_q + 1'b1;
			y400_q <= (y400_q == 9'(YEAR_CYCLE - 1)) ? '0 : y400_q + 1'b1;
		end
		if (cmd.month_step) begin
			days_q <= days_q - mlen;
			mon_q  <= mon_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_q <= {ms_q, sec_q, min_q, hour_q, 5'(days_q + 1'b1), mon_q + 4'd1, year_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ----- sv/epc_ctrl.sv -----
// ----------------------------------------------------------------------------
// epc_ctrl: converter controller
// sequences the five divisions, the year loop and the month loop
// ----------------------------------------------------------------------------
module epc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  epc_pkg::sts_t sts,
	output epc_pkg::cmd_t cmd
);
	import epc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_YEAR  = 3'd3;
	localparam logic [2:0] ST_MONTH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	op_t        op_q;
	op_t        op_d;

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		cmd            = '0;
		cmd.op         = op_q;
		in_ready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = OP_DAY;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.div_done) begin
					cmd.div_save = 1'b1;
					if (op_q == OP_MS) begin
						state_d = ST_YEAR;
					end else begin
						op_d    = op_q + 1'b1;
						state_d = ST_START;
					end
				end
			end
			ST_YEAR: begin
				if (sts.year_more) begin
					cmd.year_step = 1'b1;
				end else begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (sts.month_more) begin
					cmd.month_step = 1'b1;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_DAY;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

endmodule

// ----- sv/epoch_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_to_calendar: unix seconds and nanoseconds to utc calendar fields
// splits seconds into days and time of day, removes whole years and months
//
//  port group   direction  payload
//  s_axis       in         epoch_seconds, nanos
//  m_axis       out        year, month, day, hour, minute, second, millis
//
// one request at a time; a request runs the five divisions in the shared constant
// divider, then removes the years left in the 400 year cycle (up to 399) one by
// one and then the months (up to 11) one by one
// a new request is taken while the previous result waits on m_axis; a result
// that cannot leave holds the next one in the controller
// reset clears only control state
// ----------------------------------------------------------------------------
module epoch_to_calendar #(
	parameter int unsigned SECONDS_WIDTH = 34
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// epoch_seconds, nanos, zero pad
	input  logic [((SECONDS_WIDTH + epc_pkg::NANOS_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// year, month, day, hour, minute, second, millis
	output logic [epc_pkg::RESULT_W-1:0] m_axis_tdata
);
	import epc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	epc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	epc_dp #(.SW(SECONDS_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.secs      (s_axis_tdata[SECONDS_WIDTH-1:0]),
		.nanos     (s_axis_tdata[SECONDS_WIDTH+NANOS_W-1:SECONDS_WIDTH]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
